// ===== hdl/fixed_huffman_run_deflate_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-Huffman run deflate block
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_HUFFMAN_RUN_DEFLATE_MACROS_SVH
`define FIXED_HUFFMAN_RUN_DEFLATE_MACROS_SVH

// Consequence must hold in the cycle after the antecedent, outside reset.
`define FHRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle right after reset was applied.
`define FHRD_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fhrd_pkg.sv =====
// ----------------------------------------------------------------------------
// fhrd_pkg
// Types, constants and code tables of the fixed-Huffman run deflate block.
// ----------------------------------------------------------------------------
package fhrd_pkg;

   localparam int MAX_RUN     = 258;
   localparam int RUN_W       = 9;
   localparam int TOK_BITS_W  = 21;
   localparam int GRP_CNT_W   = 5;
   localparam int ACC_W       = 29;
   localparam int TOKEN_DEPTH = 4;
   localparam int OUT_DEPTH   = 2;

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      TOK_LIT,
      TOK_MATCH,
      TOK_EOB
   } tok_kind_type;

   // One decided token: a literal byte, a length/distance pair or end of block.
   typedef struct packed {
      tok_kind_type     kind;
      logic [RUN_W-1:0] value;
      logic             far;
   } token_type;

   // Bits of one token in stream order, LSB first.
   typedef struct packed {
      logic [TOK_BITS_W-1:0] bits;
      logic [GRP_CNT_W-1:0]  count;
   } bit_group_type;

   localparam logic [8:0] LEN_BASE [29] = '{
      9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
      9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
      9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
   localparam logic [2:0] LEN_EXTRA [29] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd0};

   localparam logic [4:0] DIST_FAR_BITS = 5'b11000;

   function automatic logic [4:0] len_code(input logic [8:0] len);
      logic [4:0] c;
      c = 5'd0;
      for (int i = 1; i < 29; i++) begin
         if (LEN_BASE[i] <= len) begin
            c = 5'(i);
         end
      end
      return c;
   endfunction

   // Huffman codes go out most significant bit first.
   function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] n);
      logic [8:0] r;
      r = 9'd0;
      for (int i = 0; i < 9; i++) begin
         if (4'(i) < n) begin
            r[i] = code[4'(n - 4'd1 - 4'(i))];
         end
      end
      return r;
   endfunction

   function automatic bit_group_type encode(input token_type t, input logic add_header);
      bit_group_type g;
      logic [8:0]    code;
      logic [3:0]    nsym;
      logic [4:0]    lc;
      logic [8:0]    extra;
      logic [2:0]    nextra;
      code   = 9'd0;
      nsym   = 4'd7;
      lc     = 5'd0;
      extra  = 9'd0;
      nextra = 3'd0;
      g.bits  = '0;
      g.count = '0;
      case (t.kind)
         TOK_LIT: begin
            if (t.value < 9'd144) begin
               code = 9'h030 + t.value;
               nsym = 4'd8;
            end else begin
               code = 9'h190 + (t.value - 9'd144);
               nsym = 4'd9;
            end
            g.bits  = TOK_BITS_W'(rev_code(code, nsym));
            g.count = GRP_CNT_W'(nsym);
         end
         TOK_MATCH: begin
            lc = len_code(t.value);
            if (lc < 5'd23) begin
               code = 9'(lc) + 9'd1;
               nsym = 4'd7;
            end else begin
               code = 9'h0C0 + 9'(lc - 5'd23);
               nsym = 4'd8;
            end
            extra  = t.value - LEN_BASE[lc];
            nextra = LEN_EXTRA[lc];
            g.bits = TOK_BITS_W'(rev_code(code, nsym))
                   | (TOK_BITS_W'(extra) << nsym)
                   | (TOK_BITS_W'(t.far ? DIST_FAR_BITS : 5'd0) << (nsym + 4'(nextra)));
            g.count = GRP_CNT_W'(nsym) + GRP_CNT_W'(nextra) + GRP_CNT_W'(5);
         end
         TOK_EOB: begin
            g.bits  = '0;
            g.count = GRP_CNT_W'(7);
         end
         default: begin
            g.bits  = '0;
            g.count = '0;
         end
      endcase
      if (add_header) begin
         g.bits  = {g.bits[TOK_BITS_W-4:0], 3'b011};
         g.count = g.count + GRP_CNT_W'(3);
      end
      return g;
   endfunction

endpackage

// ===== hdl/fhrd_fifo.sv =====
// ----------------------------------------------------------------------------
// fhrd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module fhrd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/fhrd_front.sv =====
// ----------------------------------------------------------------------------
// fhrd_front
// Keeps the byte window and run lengths and decides one token per cycle while the token queue has room.
// ----------------------------------------------------------------------------
module fhrd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  fhrd_pkg::byte_type  req_data_byte,
   input  logic                req_is_final,
   output logic                tok_push,
   output fhrd_pkg::token_type tok_data,
   input  logic                tok_full
);
   import fhrd_pkg::*;

   typedef struct packed {
      byte_type [3:0]   pend;
      byte_type [3:0]   hist;
      logic [2:0]       hc;
      logic [RUN_W-1:0] pc;
      logic [RUN_W-1:0] rn;
      logic [RUN_W-1:0] rf;
   } win_state_type;

   win_state_type st_ff, st_in, shifted, cs;
   logic          fin_ff, loop_ff, loop_in, cf, do_step;
   logic          en1, en4, go, tok_valid;
   logic [RUN_W-1:0] best, span;
   logic          best_far;
   logic [3:0]    hc_sum;
   token_type     tok;

   function automatic byte_type win(input win_state_type s, input logic [2:0] k);
      return k[2] ? s.hist[k[1:0]] : s.pend[k[1:0]];
   endfunction

   function automatic logic alive(input win_state_type s);
      logic an, af;
      an = (s.hc >= 3'd1) && (s.rn == s.pc) && (s.rn < RUN_W'(MAX_RUN));
      af = (s.hc >= 3'd4) && (s.rf == s.pc) && (s.rf < RUN_W'(MAX_RUN));
      return an || af;
   endfunction

   // Run length from the cursor at distance d; the cursor lies within the window.
   function automatic logic [RUN_W-1:0] measure(input win_state_type s, input logic [2:0] d);
      logic [RUN_W-1:0] r;
      logic             chain;
      logic [2:0]       idx;
      r     = '0;
      chain = (s.hc >= d);
      for (int i = 0; i < 8; i++) begin
         idx = s.pc[2:0] - 3'd1 - 3'(i);
         if (chain && (RUN_W'(i) < s.pc) && (win(s, idx) == win(s, idx + d))) begin
            r = RUN_W'(i + 1);
         end else begin
            chain = 1'b0;
         end
      end
      return r;
   endfunction

   // Window and runs after taking in a new byte.
   always_comb begin
      span         = st_ff.pc;
      shifted      = st_ff;
      shifted.hist = {st_ff.hist[2:0], st_ff.pend[3]};
      shifted.pend = {st_ff.pend[2:0], req_data_byte};
      if ((st_ff.hc >= 3'd1) && (st_ff.rn == span) && (st_ff.rn < RUN_W'(MAX_RUN))
          && (req_data_byte == st_ff.pend[0])) begin
         shifted.rn = st_ff.rn + RUN_W'(1);
      end
      if ((st_ff.hc >= 3'd4) && (st_ff.rf == span) && (st_ff.rf < RUN_W'(MAX_RUN))
          && (req_data_byte == st_ff.pend[3])) begin
         shifted.rf = st_ff.rf + RUN_W'(1);
      end
      shifted.pc = (span == RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : span + RUN_W'(1);
   end

   // One token decision on the current state.
   always_comb begin
      cs  = loop_ff ? st_ff : shifted;
      cf  = loop_ff ? fin_ff : req_is_final;
      en1 = (cs.hc >= 3'd1);
      en4 = (cs.hc >= 3'd4);
      go  = (cs.pc != '0) && (cf || !alive(cs));
      best     = '0;
      best_far = 1'b0;
      if (en1 && (cs.rn > best)) begin
         best = cs.rn;
      end
      if (en4 && (cs.rf > best)) begin
         best     = cs.rf;
         best_far = 1'b1;
      end
      st_in      = cs;
      tok.kind   = TOK_EOB;
      tok.value  = '0;
      tok.far    = 1'b0;
      tok_valid  = 1'b0;
      hc_sum     = '0;
      if (go) begin
         tok_valid = 1'b1;
         if (best < RUN_W'(3)) begin
            tok.kind  = TOK_LIT;
            tok.value = {1'b0, win(cs, cs.pc[2:0] - 3'd1)};
            st_in.pc  = cs.pc - RUN_W'(1);
            st_in.hc  = (cs.hc == 3'd4) ? 3'd4 : cs.hc + 3'd1;
            st_in.rn  = (en1 && (cs.rn != '0)) ? cs.rn - RUN_W'(1) : measure(st_in, 3'd1);
            st_in.rf  = (en4 && (cs.rf != '0)) ? cs.rf - RUN_W'(1) : measure(st_in, 3'd4);
         end else begin
            tok.kind  = TOK_MATCH;
            tok.value = best;
            tok.far   = best_far;
            st_in.pc  = (best < cs.pc) ? cs.pc - best : '0;
            hc_sum    = {1'b0, cs.hc} + {1'b0, best[2:0]};
            st_in.hc  = ((best >= RUN_W'(4)) || (hc_sum > 4'd4)) ? 3'd4 : hc_sum[2:0];
            st_in.rn  = measure(st_in, 3'd1);
            st_in.rf  = measure(st_in, 3'd4);
         end
      end else if (cf) begin
         tok_valid = 1'b1;
         tok.kind  = TOK_EOB;
         st_in.hc  = '0;
         st_in.pc  = '0;
         st_in.rn  = '0;
         st_in.rf  = '0;
      end
      loop_in = tok_valid && (tok.kind != TOK_EOB)
              && (cf || ((st_in.pc != '0) && !alive(st_in)));
   end

   assign do_step  = !tok_full && (loop_ff || req_push);
   assign req_full = loop_ff || tok_full;
   assign tok_push = do_step && tok_valid;
   assign tok_data = tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.hc <= '0;
         st_ff.pc <= '0;
         st_ff.rn <= '0;
         st_ff.rf <= '0;
         fin_ff   <= 1'b0;
         loop_ff  <= 1'b0;
      end else if (do_step) begin
         st_ff.hc <= st_in.hc;
         st_ff.pc <= st_in.pc;
         st_ff.rn <= st_in.rn;
         st_ff.rf <= st_in.rf;
         fin_ff   <= cf;
         loop_ff  <= loop_in;
      end
      if (do_step) begin
         st_ff.pend <= st_in.pend;
         st_ff.hist <= st_in.hist;
      end
   end

endmodule

// ===== hdl/fhrd_back.sv =====
// ----------------------------------------------------------------------------
// fhrd_back
// Turns tokens into fixed Huffman bits and packs them into bytes.
// ----------------------------------------------------------------------------
module fhrd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_empty,
   input  fhrd_pkg::token_type tok_data,
   output logic                tok_pop,
   output logic                out_push,
   output logic [8:0]          out_data,
   input  logic                out_full
);
   import fhrd_pkg::*;

   logic [ACC_W-1:0]     acc_ff, acc_in, acc_mid;
   logic [GRP_CNT_W-1:0] cnt_ff, cnt_in, cnt_mid;
   logic                 hdr_ff, hdr_in, final_ff, final_in, final_mid;
   logic                 emit, eos, absorb;
   bit_group_type        grp;

   always_comb begin
      eos  = final_ff && (cnt_ff <= GRP_CNT_W'(8));
      emit = !out_full && ((cnt_ff >= GRP_CNT_W'(8)) || (final_ff && (cnt_ff != '0)));
      acc_mid   = acc_ff;
      cnt_mid   = cnt_ff;
      final_mid = final_ff;
      if (emit) begin
         if (eos) begin
            acc_mid   = '0;
            cnt_mid   = '0;
            final_mid = 1'b0;
         end else begin
            acc_mid = acc_ff >> 8;
            cnt_mid = cnt_ff - GRP_CNT_W'(8);
         end
      end
      grp    = encode(tok_data, !hdr_ff);
      absorb = !tok_empty && !final_ff && (cnt_mid < GRP_CNT_W'(8));
      acc_in   = acc_mid;
      cnt_in   = cnt_mid;
      hdr_in   = hdr_ff;
      final_in = final_mid;
      if (absorb) begin
         acc_in = acc_mid | (ACC_W'(grp.bits) << cnt_mid);
         cnt_in = cnt_mid + grp.count;
         if (tok_data.kind == TOK_EOB) begin
            hdr_in   = 1'b0;
            final_in = 1'b1;
         end else begin
            hdr_in = 1'b1;
         end
      end
   end

   assign tok_pop  = absorb;
   assign out_push = emit;
   assign out_data = {eos, acc_ff[7:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         hdr_ff   <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         hdr_ff   <= hdr_in;
         final_ff <= final_in;
      end
   end

endmodule

// ===== hdl/fixed_huffman_run_deflate.sv =====
// After the transaction that closes a token is accepted, its first packed byte passes the
// token queue, the packer's accumulator and the output queue. Throughput: one input byte per
// cycle while the token queue has room and the byte's token is decided at once; a byte that
// needs more decisions (a broken run, the stream end) holds the input until they are made.
// The packer sends at most one byte per cycle, so output bandwidth bounds sustained rate.
// Reset is synchronous and active high; it empties both queues and starts a new stream.
// ----------------------------------------------------------------------------
// fixed_huffman_run_deflate
// Byte stream to one final fixed-Huffman deflate block using runs at distance 1 and 4.
// ----------------------------------------------------------------------------
module fixed_huffman_run_deflate #(
   parameter int TOKEN_DEPTH = fhrd_pkg::TOKEN_DEPTH,
   parameter int OUT_DEPTH   = fhrd_pkg::OUT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  fhrd_pkg::byte_type req_data_byte,
   input  logic               req_is_final,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output fhrd_pkg::byte_type rsp_packed_byte,
   output logic               rsp_end_of_stream
);
   import fhrd_pkg::*;

   // The front end owns the eight-byte window and the two run counters. Each
   // transaction on the request side either extends a live run (no token yet)
   // or lets the front end decide a literal, a match or the end-of-block code.
   token_type tq_push_data, tq_pop_data;
   logic      tq_push, tq_full, tq_pop, tq_empty;

   // Packed bytes and their end-of-stream flag travel together.
   logic [8:0] oq_push_data, oq_pop_data;
   logic       oq_push, oq_full;

   fhrd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_is_final  (req_is_final),
      .tok_push      (tq_push),
      .tok_data      (tq_push_data),
      .tok_full      (tq_full)
   );

   // The token queue decouples the decision logic from the bit packer, so a
   // long match that expands into several bytes does not stall new input.
   fhrd_fifo #(
      .WIDTH ($bits(token_type)),
      .DEPTH (TOKEN_DEPTH)
   ) u_token_q (
      .clock     (clock),
      .reset     (reset),
      .push      (tq_push),
      .push_data (tq_push_data),
      .full      (tq_full),
      .pop       (tq_pop),
      .pop_data  (tq_pop_data),
      .empty     (tq_empty)
   );

   // The back end prepends the block header to the first token of a stream,
   // packs the bits into bytes LSB first and pads the last byte with zeros.
   fhrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (tq_empty),
      .tok_data  (tq_pop_data),
      .tok_pop   (tq_pop),
      .out_push  (oq_push),
      .out_data  (oq_push_data),
      .out_full  (oq_full)
   );

   // The output queue lets the packer keep going while a byte waits to be taken.
   fhrd_fifo #(
      .WIDTH (9),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (oq_push),
      .push_data (oq_push_data),
      .full      (oq_full),
      .pop       (rsp_pop),
      .pop_data  (oq_pop_data),
      .empty     (rsp_empty)
   );

   assign rsp_packed_byte   = oq_pop_data[7:0];
   assign rsp_end_of_stream = oq_pop_data[8];

endmodule

// ===== hdl/fhrd_checker.sv =====
// ----------------------------------------------------------------------------
// fhrd_checker
// Port-level checks of the run deflate block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_huffman_run_deflate_macros.svh"

module fhrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_packed_byte,
   input logic       rsp_end_of_stream
);
   // Nothing is left to deliver right after reset.
   `FHRD_ASSERT_AFTER_RESET(a_empty_after_reset, clock, reset, rsp_empty, "result after reset")

   // The block is ready for a new transaction right after reset.
   `FHRD_ASSERT_AFTER_RESET(a_ready_after_reset, clock, reset, !req_full, "full after reset")

   // A waiting result holds until it is taken.
   `FHRD_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_packed_byte) && $stable(rsp_end_of_stream), "result changed")

endmodule

bind fixed_huffman_run_deflate fhrd_checker u_fhrd_checker (.*);

// ===== test/fixed_huffman_run_deflate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_huffman_run_deflate_tb
// Feeds byte streams into the run deflate encoder and checks every packed
// byte against an in-bench encoder model, under random flow control.
// ----------------------------------------------------------------------------
module fixed_huffman_run_deflate_tb;
   import fhrd_pkg::*;

   typedef struct {
      byte_type value;
      bit       eos;
   } packed_out_type;

   // One row of the directed table. Rows with known bytes also carry the
   // complete packed output of their one-byte stream.
   typedef struct {
      byte_type data;
      bit       fin;
      int       n_known;
      byte_type known [3];
   } stim_row_type;

   logic     clock;
   logic     reset;
   logic     req_push;
   logic     req_full;
   byte_type req_data_byte;
   logic     req_is_final;
   logic     rsp_empty;
   logic     rsp_pop;
   byte_type rsp_packed_byte;
   logic     rsp_end_of_stream;

   // Encoder model state: a window of eight bytes, run lengths and the bit packer.
   byte_type    hist [4];
   byte_type    pend [4];
   int unsigned hist_cnt, pend_cnt, run_near, run_far, bit_acc, bit_cnt;
   bit          header_done;
   int          step_bytes;

   packed_out_type expected_bytes [$];
   packed_out_type known_bytes [$];
   int             errors;
   int             burst_left;

   fixed_huffman_run_deflate dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_is_final      (req_is_final),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_packed_byte   (rsp_packed_byte),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: the slowest legal run is far shorter than this.
   initial begin
      #5ms;
      $display("fixed_huffman_run_deflate test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Encoder model
   // ------------------------------------------------------------------------
   task automatic clear_encoder();
      for (int k = 0; k < 4; k++) begin
         hist[k] = '0;
         pend[k] = '0;
      end
      hist_cnt    = 0;
      pend_cnt    = 0;
      run_near    = 0;
      run_far     = 0;
      bit_acc     = 0;
      bit_cnt     = 0;
      header_done = 1'b0;
   endtask

   // Index 0 is the newest byte; indexes 4 to 7 reach into the history.
   function automatic byte_type window_byte(int unsigned k);
      k = k & 7;
      return (k < 4) ? pend[k] : hist[k - 4];
   endfunction

   // At most eight packed bytes come from one input byte.
   task automatic emit_packed(byte_type v, bit eos);
      packed_out_type entry;
      if (step_bytes < 8) begin
         entry.value = v;
         entry.eos   = eos;
         expected_bytes.insert(expected_bytes.size(), entry);
         step_bytes++;
      end
   endtask

   task automatic put_bits(int unsigned value, int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
         bit_acc |= ((value >> k) & 1) << bit_cnt;
         bit_cnt++;
         if (bit_cnt == 8) begin
            emit_packed(byte_type'(bit_acc), 1'b0);
            bit_acc = 0;
            bit_cnt = 0;
         end
      end
   endtask

   // Huffman codes are sent most significant bit first.
   task automatic put_code(int unsigned code, int unsigned n);
      for (int unsigned k = n; k > 0; k--) begin
         put_bits((code >> (k - 1)) & 1, 1);
      end
   endtask

   task automatic put_symbol(int unsigned s);
      if (s < 144) put_code(32'h30 + s, 8);
      else if (s < 256) put_code(32'h190 + (s - 144), 9);
      else if (s < 280) put_code(s - 256, 7);
      else put_code(32'hC0 + (s - 280), 8);
   endtask

   task automatic put_match(int unsigned len, int unsigned match_dist);
      int unsigned code;
      code = 28;
      while (code > 0 && LEN_BASE[code] > len) code--;
      put_symbol(257 + code);
      put_bits(len - LEN_BASE[code], LEN_EXTRA[code]);
      put_code((match_dist == 1) ? 0 : 3, 5);
   endtask

   function automatic int unsigned run_length(int unsigned d);
      int unsigned r;
      r = 0;
      if (hist_cnt < d) return 0;
      while (r < pend_cnt && r < MAX_RUN &&
             window_byte(pend_cnt - 1 - r) == window_byte(pend_cnt - 1 - r + d)) r++;
      return r;
   endfunction

   task automatic advance_cursor(int unsigned n);
      pend_cnt = (n < pend_cnt) ? pend_cnt - n : 0;
      hist_cnt = (hist_cnt + n > 4) ? 4 : hist_cnt + n;
   endtask

   // Works out the packed bytes that one accepted input byte releases.
   task automatic encode_byte(byte_type x, bit fin);
      int unsigned span, best, match_dist;
      bit          en1, en4, alive_n, alive_f;
      step_bytes = 0;
      if (!header_done) begin
         put_bits(3, 3);
         header_done = 1'b1;
      end
      span = pend_cnt;
      for (int k = 3; k > 0; k--) hist[k] = hist[k - 1];
      hist[0] = pend[3];
      for (int k = 3; k > 0; k--) pend[k] = pend[k - 1];
      pend[0] = x;
      en1 = hist_cnt >= 1;
      en4 = hist_cnt >= 4;
      if (en1 && run_near == span && run_near < MAX_RUN && window_byte(0) == window_byte(1))
         run_near++;
      if (en4 && run_far == span && run_far < MAX_RUN && window_byte(0) == window_byte(4))
         run_far++;
      pend_cnt = (span + 1 > MAX_RUN) ? MAX_RUN : span + 1;

      while (pend_cnt > 0) begin
         best       = 0;
         match_dist = 0;
         en1        = hist_cnt >= 1;
         en4        = hist_cnt >= 4;
         alive_n    = en1 && run_near == pend_cnt && run_near < MAX_RUN;
         alive_f    = en4 && run_far == pend_cnt && run_far < MAX_RUN;
         // An unbroken run may still grow, so the decision waits.
         if (!fin && (alive_n || alive_f)) break;
         if (en1 && run_near > best) begin
            best       = run_near;
            match_dist = 1;
         end
         if (en4 && run_far > best) begin
            best       = run_far;
            match_dist = 4;
         end
         if (best < 3) begin
            put_symbol(window_byte(pend_cnt - 1));
            advance_cursor(1);
            if (en1 && run_near > 0) run_near--; else run_near = run_length(1);
            if (en4 && run_far > 0) run_far--; else run_far = run_length(4);
         end else begin
            put_match(best, match_dist);
            advance_cursor(best);
            run_near = run_length(1);
            run_far  = run_length(4);
         end
      end

      if (fin) begin
         put_symbol(256);
         if (bit_cnt > 0) begin
            emit_packed(byte_type'(bit_acc), 1'b1);
         end else if (step_bytes > 0) begin
            // The end-of-block code filled the last byte exactly.
            expected_bytes[$].eos = 1'b1;
         end
         clear_encoder();
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Every accepted input transaction feeds the model.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) encode_byte(req_data_byte, req_is_final);
   end

   // Every accepted output transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      packed_out_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", rsp_packed_byte, 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_packed_byte !== want.value)
               report_mismatch("packed_byte", rsp_packed_byte, want.value);
            if (rsp_end_of_stream !== want.eos)
               report_mismatch("end_of_stream", rsp_end_of_stream, want.eos);
         end
         // The first streams also have their bytes written out by hand.
         if (known_bytes.size() > 0) begin
            want = known_bytes.pop_front();
            if (rsp_packed_byte !== want.value || rsp_end_of_stream !== want.eos)
               report_mismatch("known byte", rsp_packed_byte, want.value);
         end
      end
   end

   // The receiver switches among free flow, random stalls and a periodic stall.
   initial begin
      int cyc;
      cyc     = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         case ((cyc / 97) % 3)
            0: rsp_pop = 1'b1;
            1: rsp_pop = 1'($urandom_range(0, 1));
            default: rsp_pop = (cyc % 5) != 0;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   // Sends one byte; the sender works in bursts separated by random idle gaps.
   task automatic send_byte(byte_type x, bit fin);
      if (burst_left == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_push      = 1'b1;
      req_data_byte = x;
      req_is_final  = fin;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      req_push = 1'b0;
      burst_left--;
   endtask

   task automatic send_stream(int len, int mode);
      byte_type x, seed [4];
      for (int k = 0; k < 4; k++) seed[k] = byte_type'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: x = byte_type'($urandom_range(0, 255));
            1: x = ($urandom_range(0, 15) == 0) ? byte_type'($urandom_range(0, 255)) : seed[0];
            2: x = ($urandom_range(0, 15) == 0) ? byte_type'($urandom_range(0, 255))
                                                : seed[i % 4];
            default: x = seed[$urandom_range(0, 1)];
         endcase
         send_byte(x, i == len - 1);
      end
   endtask

   stim_row_type directed [23] = '{
      // Single-byte streams with their packed bytes worked out by hand.
      '{8'h00, 1'b1, 3, '{8'h63, 8'h00, 8'h00}},
      '{8'hFF, 1'b1, 3, '{8'hFB, 8'h0F, 8'h00}},
      // Literal code boundary: 143 is the last 8-bit literal, 144 the first 9-bit one.
      '{8'h8F, 1'b0, 0, '{0, 0, 0}},
      '{8'h90, 1'b0, 0, '{0, 0, 0}},
      '{8'h55, 1'b1, 0, '{0, 0, 0}},
      // A run at distance 1 that ends with the stream.
      '{8'hAA, 1'b0, 0, '{0, 0, 0}},
      '{8'hAA, 1'b0, 0, '{0, 0, 0}},
      '{8'hAA, 1'b0, 0, '{0, 0, 0}},
      '{8'hAA, 1'b0, 0, '{0, 0, 0}},
      '{8'hAA, 1'b0, 0, '{0, 0, 0}},
      '{8'hAA, 1'b0, 0, '{0, 0, 0}},
      '{8'h3C, 1'b1, 0, '{0, 0, 0}},
      // A repeating four-byte pattern, matched at distance 4, then broken.
      '{8'h01, 1'b0, 0, '{0, 0, 0}},
      '{8'h02, 1'b0, 0, '{0, 0, 0}},
      '{8'h03, 1'b0, 0, '{0, 0, 0}},
      '{8'h04, 1'b0, 0, '{0, 0, 0}},
      '{8'h01, 1'b0, 0, '{0, 0, 0}},
      '{8'h02, 1'b0, 0, '{0, 0, 0}},
      '{8'h03, 1'b0, 0, '{0, 0, 0}},
      '{8'h04, 1'b0, 0, '{0, 0, 0}},
      '{8'h01, 1'b0, 0, '{0, 0, 0}},
      '{8'h77, 1'b0, 0, '{0, 0, 0}},
      '{8'h80, 1'b1, 0, '{0, 0, 0}}
   };

   initial begin
      int             sent, len, waited;
      packed_out_type entry;
      errors        = 0;
      burst_left    = 0;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_data_byte = '0;
      req_is_final  = 1'b0;
      clear_encoder();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         for (int k = 0; k < directed[i].n_known; k++) begin
            entry.value = directed[i].known[k];
            entry.eos   = (k == directed[i].n_known - 1);
            known_bytes.insert(known_bytes.size(), entry);
         end
         send_byte(directed[i].data, directed[i].fin);
      end

      // Random streams: mostly runs and patterns, some plain noise.
      sent = 0;
      while (sent < 195) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
         send_stream(len, $urandom_range(0, 3));
         sent += len;
      end

      waited = 0;
      while (expected_bytes.size() > 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("fixed_huffman_run_deflate test passed");
      end else begin
         $display("fixed_huffman_run_deflate test failed");
      end
      $finish;
   end

endmodule
